@@ rtl/ult_pkg.sv @@
// shared types and constants for the unsorted list table
package ult_pkg;

	localparam int ULT_DEPTH = 64;
	localparam int OP_W      = 3;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 6;
	localparam int HELD_W    = 7;
	localparam int STATUS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_SEARCH = 3'd2,
		OP_UPDATE = 3'd3,
		OP_DUMP   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_PICK,
		S_APPLY,
		S_DUMP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic match;
		logic pick;
		logic apply;
		logic dump_step;
	} ult_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic is_dump;
		logic empty;
		logic dump_last;
	} ult_stat_t;

endpackage

@@ rtl/ult_if.sv @@
// request and result channel interfaces
interface ult_req_if
	import ult_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] new_value;

	modport source (output valid, output op, output key, output new_value, input ready);
	modport sink   (input valid, input op, input key, input new_value, output ready);
endinterface

interface ult_rsp_if
	import ult_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] entry_value;
	logic [HELD_W-1:0]        entries_held;
	logic                     last;

	modport source (output valid, output status, output position, output entry_value,
		output entries_held, output last, input ready);
	modport sink   (input valid, input status, input position, input entry_value,
		input entries_held, input last, output ready);
endinterface

@@ rtl/ult_ctrl.sv @@
// sequencing state machine for the unsorted list table
module ult_ctrl
	import ult_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ult_stat_t stat,
	output ult_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_APPLY;
			end
			S_APPLY: begin
				if (stat.is_dump && !stat.empty) begin
					state_d = S_DUMP;
				end else if (stat.slot_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_DUMP: begin
				if (stat.slot_free) begin
					cmd.dump_step = 1'b1;
					if (stat.dump_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/ult_dp.sv @@
// entry cells, match logic and result register for the unsorted list table
module ult_dp
	import ult_pkg::*;
#(
	parameter int DEPTH = ULT_DEPTH
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ult_cmd_t                 cmd,
	output ult_stat_t                stat,
	input  logic [OP_W-1:0]          op,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] new_value,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [STATUS_W-1:0]      status,
	output logic [POS_W-1:0]         position,
	output logic signed [DATA_W-1:0] entry_value,
	output logic [HELD_W-1:0]        entries_held,
	output logic                     last
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] nv_q;
	logic [DATA_W-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0]  fill_q;
	logic [DEPTH-1:0]  hit_s1;
	logic [IDX_W-1:0]  idx_s2;
	logic              found_s2;
	logic [IDX_W-1:0]  dump_idx_q;

	logic [IDX_W-1:0]    idx_d;
	logic                full;
	logic                dump_last;
	logic                slot_free;
	logic                do_insert;
	logic                do_delete;
	logic                do_update;
	logic [STATUS_W-1:0] res_status;
	logic [POS_W-1:0]    res_pos;
	logic [CNT_W-1:0]    fill_d;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			key_q <= key;
			nv_q  <= new_value;
		end
	end

	// priority encode of the first hit
	always_comb begin
		idx_d = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit_s1[i]) begin
				idx_d = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			idx_s2   <= idx_d;
			found_s2 <= |hit_s1;
		end
	end

	assign full      = (fill_q == CNT_W'(DEPTH));
	assign dump_last = (CNT_W'(dump_idx_q) + CNT_W'(1) == fill_q);
	assign slot_free = !out_valid || out_ready;

	assign do_insert = cmd.apply && (op_q == OP_INSERT) && !full;
	assign do_delete = cmd.apply && (op_q == OP_DELETE) && found_s2;
	assign do_update = cmd.apply && (op_q == OP_UPDATE) && found_s2;

	// compare cells and move data
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.match) begin
				hit_s1[j] <= (cell_q[j] == key_q) && (CNT_W'(j) < fill_q);
			end
		end

		always_ff @(posedge clk) begin
			if (do_insert && (fill_q == CNT_W'(j))) begin
				cell_q[j] <= key_q;
			end else if (do_update && (idx_s2 == IDX_W'(j))) begin
				cell_q[j] <= nv_q;
			end else if (do_delete && (CNT_W'(idx_s2) <= CNT_W'(j))) begin
				if (j < DEPTH - 1) begin
					cell_q[j] <= cell_q[(j + 1) % DEPTH];
				end
			end else if (cmd.dump_step) begin
				// rotate the held entries by one so that cell zero is always next
				if (CNT_W'(j + 1) == fill_q) begin
					cell_q[j] <= cell_q[0];
				end else if (CNT_W'(j + 1) < fill_q) begin
					cell_q[j] <= cell_q[(j + 1) % DEPTH];
				end
			end
		end
	end

	always_comb begin
		res_status = ST_DONE;
		res_pos    = '0;
		fill_d     = fill_q;
		case (op_q)
			OP_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					fill_d = fill_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (found_s2) begin
					fill_d = fill_q - CNT_W'(1);
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			OP_SEARCH, OP_UPDATE: begin
				if (found_s2) begin
					res_pos = POS_W'(idx_s2);
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			OP_DUMP: begin
				res_status = ST_EMPTY;
			end
			default: begin
				res_status = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			dump_idx_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.apply) begin
				fill_q <= fill_d;
			end
			if (cmd.dump_step) begin
				dump_idx_q <= dump_last ? '0 : dump_idx_q + IDX_W'(1);
			end
			if (cmd.apply || cmd.dump_step) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status       <= res_status;
			position     <= res_pos;
			entry_value  <= '0;
			entries_held <= HELD_W'(fill_d);
			last         <= 1'b1;
		end else if (cmd.dump_step) begin
			status       <= ST_DONE;
			position     <= POS_W'(dump_idx_q);
			entry_value  <= cell_q[0];
			entries_held <= HELD_W'(fill_q);
			last         <= dump_last;
		end
	end

	assign stat.slot_free = slot_free;
	assign stat.is_dump   = (op_q == OP_DUMP);
	assign stat.empty     = (fill_q == '0);
	assign stat.dump_last = dump_last;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dump_step |-> (fill_q != '0) && slot_free)
		else $error("dump step on empty list or busy result slot");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.apply && cmd.dump_step))
		else $error("two results loaded at once");

	a_dump_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dump_step && dump_last) |=> dump_idx_q == '0)
		else $error("dump index not returned to zero");

endmodule

@@ rtl/unsorted_list_table.sv @@
// top level of the unsorted list table
//
// channel  dir  handshake     payload
// req      in   valid/ready   op, key, new_value
// rsp      out  valid/ready   status, position, entry_value, entries_held, last
//
// one request at a time: insert, delete, search, update and unused ops pass from
// acceptance to the result register through capture, compare, encode and apply
// a dump runs capture, compare and encode, then emits one entry per dump step from
// the single result register that cell zero feeds while the cells rotate
// reset clears the entry count and control state; cell contents stay undefined
// a stalled result only holds back the apply or dump step, the cells keep their data
module unsorted_list_table
	import ult_pkg::*;
#(
	parameter int DEPTH = ULT_DEPTH
)(
	input  logic  clk,
	input  logic  arst_n,
	ult_req_if.sink   req,
	ult_rsp_if.source rsp
);

	ult_cmd_t  cmd;
	ult_stat_t stat;

	// sequencer: walks each request through capture, compare, encode and apply, or the dump steps
	ult_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// cell row with parallel match, shift on delete and rotate on dump
	ult_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (req.op),
		.key          (req.key),
		.new_value    (req.new_value),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.status       (rsp.status),
		.position     (rsp.position),
		.entry_value  (rsp.entry_value),
		.entries_held (rsp.entries_held),
		.last         (rsp.last)
	);

endmodule
